[sv/xsrg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xsrg_pkg
// shared types, constants and seed derivation for the xorshift128 range
// generator
// ----------------------------------------------------------------------------
package xsrg_pkg;

    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [31:0] SEED_W_RST = 32'd88675123;
    localparam logic [31:0] SEED_X_RST = 32'd123456789;
    localparam logic [31:0] SEED_Y_RST = 32'd362436069;
    localparam logic [31:0] SEED_Z_RST = 32'd521288629;

    typedef enum logic [1:0] {
        REG_SEED_W = 2'd0,
        REG_SEED_X = 2'd1,
        REG_SEED_Y = 2'd2,
        REG_SEED_Z = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_words;

    typedef struct packed {
        logic [31:0] raw;
        logic [31:0] lo;
        logic [31:0] span;
        logic [31:0] count;
    } t_job;

    function automatic t_words load_words(input logic [31:0] sw, input logic [31:0] sx,
                                          input logic [31:0] sy, input logic [31:0] sz);
        t_words w;
        w.a = (sx != 32'd0) ? sx : (sw << 13);
        w.b = (sy != 32'd0) ? sy : ((sw >> 9) ^ (w.a << 6));
        w.c = (sz != 32'd0) ? sz : (w.b >> 7);
        w.d = sw;
        return w;
    endfunction

endpackage
`default_nettype wire

[sv/xsrg_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xsrg_front
// seed registers, config port and xorshift128 state; draws one word per
// accepted item and hands the job to the queue
// ----------------------------------------------------------------------------
module xsrg_front
    import xsrg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        push,
    input  wire logic [31:0] i_low_bound,
    input  wire logic [31:0] i_high_bound,
    input  wire logic        i_q_full,
    output logic             o_q_push,
    output t_job             o_job
);

    logic [31:0] r_seed_w, r_seed_x, r_seed_y, r_seed_z;
    logic [31:0] n_seed_w, n_seed_x, n_seed_y, n_seed_z;
    t_words      r_words;
    logic [31:0] r_count;
    logic        cfg_wr;
    logic [31:0] t_mix;
    logic [31:0] new_d;
    t_reg_idx    reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_comb begin
        n_seed_w = r_seed_w;
        n_seed_x = r_seed_x;
        n_seed_y = r_seed_y;
        n_seed_z = r_seed_z;
        case (reg_idx)
            REG_SEED_W: n_seed_w = pwdata;
            REG_SEED_X: n_seed_x = pwdata;
            REG_SEED_Y: n_seed_y = pwdata;
            REG_SEED_Z: n_seed_z = pwdata;
            default:    n_seed_w = r_seed_w;
        endcase
    end

    always_comb begin
        case (reg_idx)
            REG_SEED_W: prdata = r_seed_w;
            REG_SEED_X: prdata = r_seed_x;
            REG_SEED_Y: prdata = r_seed_y;
            REG_SEED_Z: prdata = r_seed_z;
            default:    prdata = 32'd0;
        endcase
    end

    assign t_mix    = r_words.a ^ (r_words.a << 11);
    assign new_d    = r_words.d ^ (r_words.d >> 19) ^ t_mix ^ (t_mix >> 8);
    assign o_q_push = push && !i_q_full;

    assign o_job.raw   = new_d;
    assign o_job.lo    = i_low_bound;
    assign o_job.span  = i_high_bound - i_low_bound + 32'd1;
    assign o_job.count = r_count + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_w <= SEED_W_RST;
            r_seed_x <= SEED_X_RST;
            r_seed_y <= SEED_Y_RST;
            r_seed_z <= SEED_Z_RST;
            r_words  <= load_words(SEED_W_RST, SEED_X_RST, SEED_Y_RST, SEED_Z_RST);
            r_count  <= 32'd0;
        end else if (cfg_wr) begin
            r_seed_w <= n_seed_w;
            r_seed_x <= n_seed_x;
            r_seed_y <= n_seed_y;
            r_seed_z <= n_seed_z;
            r_words  <= load_words(n_seed_w, n_seed_x, n_seed_y, n_seed_z);
            r_count  <= 32'd0;
        end else if (o_q_push) begin
            r_words.a <= r_words.b;
            r_words.b <= r_words.c;
            r_words.c <= r_words.d;
            r_words.d <= new_d;
            r_count   <= o_job.count;
        end
    end

endmodule
`default_nettype wire

[sv/xsrg_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xsrg_fifo
// short job queue between the draw front and the modulo back
// ----------------------------------------------------------------------------
module xsrg_fifo
    import xsrg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_data,
    output logic      o_empty
);

    t_job                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wptr, r_rptr;
    logic [FIFO_CW-1:0]   r_cnt;
    logic                 do_push, do_pop;

    assign o_full  = (r_cnt == FIFO_CW'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full job queue");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FIFO_CW'(FIFO_DEPTH))
        else $error("job queue count overflow");

endmodule
`default_nettype wire

[sv/xsrg_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xsrg_back
// bit-serial unsigned remainder of raw word by span, low bound added, and
// result output register
// ----------------------------------------------------------------------------
module xsrg_back
    import xsrg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_empty,
    input  t_job             i_job,
    output logic             o_q_pop,
    output logic             empty,
    input  wire logic        pop,
    output logic      [31:0] o_raw_word,
    output logic      [31:0] o_ranged_value,
    output logic      [31:0] o_draw_count
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state      r_state;
    logic [4:0]  r_bit;
    logic [31:0] r_rem, r_dvd, r_span, r_lo, r_raw, r_count;
    logic        r_out_valid;
    logic [32:0] trial;
    logic [32:0] diff;
    logic [31:0] n_rem;
    logic        out_free;
    logic        out_load;

    assign trial    = {r_rem, r_dvd[31]};
    assign diff     = trial - {1'b0, r_span};
    assign n_rem    = diff[32] ? trial[31:0] : diff[31:0];
    assign out_free = !r_out_valid || pop;
    assign out_load = (r_state == ST_DONE) && out_free;
    assign o_q_pop  = (r_state == ST_IDLE) && !i_q_empty;
    assign empty    = !r_out_valid;

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (o_q_pop) begin
                    r_raw   <= i_job.raw;
                    r_lo    <= i_job.lo;
                    r_span  <= i_job.span;
                    r_count <= i_job.count;
                    r_dvd   <= i_job.raw;
                    r_rem   <= (i_job.span == 32'd0) ? i_job.raw : 32'd0;
                    r_bit   <= 5'd31;
                end
            end
            ST_DIV: begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[30:0], 1'b0};
                r_bit <= r_bit - 5'd1;
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
        if (out_load) begin
            o_raw_word     <= r_raw;
            o_ranged_value <= r_rem + r_lo;
            o_draw_count   <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (o_q_pop) begin
                        r_state <= (i_job.span == 32'd0) ? ST_DONE : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_bit == 5'd0) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) && !out_free |=> (r_state == ST_DONE))
        else $error("finished item left before output was free");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("output register not valid after load");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == ST_IDLE) && !i_q_empty)
        else $error("job taken while busy");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) && (r_bit == 5'd0) |=> (r_state == ST_DONE))
        else $error("remainder unit did not finish");

endmodule
`default_nettype wire

[sv/xorshift128_range_generator_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xorshift128_range_generator_core
// xorshift128 generator returning raw word, ranged value and draw count
// ----------------------------------------------------------------------------
// Each accepted item draws one xorshift128 word in the cycle it is accepted
// and enters a two-entry job queue, so push is taken while the queue has
// room. The ranged value comes from a bit-serial remainder unit that retires
// one quotient bit per cycle. The back end takes the job in its idle state,
// runs 32 remainder steps (skipped when the span wraps to zero), then loads
// the output register once it is free, and takes no new job before that load.
// Results wait in an output register until popped. Writing any seed register
// reloads the state with zero seeds derived from seed_w and clears the draw count.
// ----------------------------------------------------------------------------
module xorshift128_range_generator_core
    import xsrg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] i_low_bound,
    input  wire logic [31:0] i_high_bound,
    output logic             empty,
    input  wire logic        pop,
    output logic      [31:0] o_raw_word,
    output logic      [31:0] o_ranged_value,
    output logic      [31:0] o_draw_count
);

    t_job job_in;
    t_job job_out;
    logic q_push;
    logic q_pop;
    logic q_empty;

    xsrg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .push         (push),
        .i_low_bound  (i_low_bound),
        .i_high_bound (i_high_bound),
        .i_q_full     (full),
        .o_q_push     (q_push),
        .o_job        (job_in)
    );

    xsrg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (job_out),
        .o_empty (q_empty)
    );

    xsrg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_job          (job_out),
        .o_q_pop        (q_pop),
        .empty          (empty),
        .pop            (pop),
        .o_raw_word     (o_raw_word),
        .o_ranged_value (o_ranged_value),
        .o_draw_count   (o_draw_count)
    );

endmodule
`default_nettype wire
